// ===== src/bph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bph_pkg;

    localparam int KEY_W = 32;
    localparam int CNT_W = 7;

    // request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] popped_key;
        logic [KEY_W-1:0] top_key;
        logic             top_valid;
        logic [CNT_W-1:0] entry_count;
    } t_rsp;

endpackage

`default_nettype wire

// ===== src/bph_heap_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bph_heap_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== src/binary_heap_priority_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Binary heap priority queue with a fixed capacity of CAPACITY keys.
// Input channel (i_in_valid / o_in_stall / i_in_data): each transaction is a
// push of a key or a pop of the entry with priority. Output channel
// (o_out_valid / i_out_stall / o_out_data): exactly one result transaction per
// request, carrying status, popped key, new top, non-empty flag and count.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes min_first
// (1 = smallest first, 0 = largest first); always ready, write only while idle.
// The heap lives in one synchronous RAM with two read ports. A push climbs
// one level per step; a pop first reads the last entry, then descends one
// level per step, with one RAM read and one compare/write-back per step.
// Rejected pushes and empty pops skip the heap walk and go straight to the result.
// One request is worked on at a time; o_in_stall is high while it is in flight
// and the next request is taken in the cycle after the result is loaded.
// A finished result sits in the output register, so the next request is taken
// while the receiver stalls; its result then waits until the register frees.
// Reset (synchronous, active low) empties the queue, sets min_first to 1 and
// drops any pending result. The RAM needs no clearing pass.
module binary_heap_priority_queue_core
    import bph_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // config
    input  wire logic i_cfg_valid,
    output logic      o_cfg_ready,
    input  wire logic i_cfg_data,
    // requests
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in_data,
    // results
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rsp      o_out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_UP       = 3'd1;
    localparam logic [2:0] S_DN_LAST  = 3'd2;
    localparam logic [2:0] S_DN_ISSUE = 3'd3;
    localparam logic [2:0] S_DN       = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    // true when key b strictly outranks key a
    function automatic logic f_outranks(input logic [KEY_BITS-1:0] a,
                                        input logic [KEY_BITS-1:0] b,
                                        input logic                minf);
        return minf ? (b < a) : (b > a);
    endfunction

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_min_first;
    logic [AW-1:0]       r_pos, n_pos;
    logic [KEY_BITS-1:0] r_val, n_val;
    logic [KEY_BITS-1:0] r_top;
    logic [KEY_BITS-1:0] r_popped, n_popped;
    logic [1:0]          r_status, n_status;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out;

    // RAM port
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [KEY_BITS-1:0] mem_wdata;
    logic [AW-1:0]       mem_raddr_a, mem_raddr_b;
    logic [KEY_BITS-1:0] mem_rdata_a, mem_rdata_b;

    logic                accept;
    logic                load_out;
    logic [63:0]         key_w;
    logic [63:0]         top_w;
    logic [63:0]         popped_w;
    logic [15:0]         cnt_w;
    logic [IW-1:0]       pos_ext, l_ext, r_ext, cnt_ext;
    logic [AW-1:0]       up_par, up_par2, in_pos, in_par;
    logic [CW-1:0]       cnt_m1;
    logic                left_win, right_win;
    logic [KEY_BITS-1:0] cand;
    t_rsp                rsp;

    bph_heap_mem #(
        .DEPTH(CAPACITY),
        .WIDTH(KEY_BITS),
        .AW   (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr_a(mem_raddr_a),
        .i_raddr_b(mem_raddr_b),
        .o_rdata_a(mem_rdata_a),
        .o_rdata_b(mem_rdata_b)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign key_w  = 64'(i_in_data.key);

    // heap index arithmetic
    assign pos_ext = IW'(r_pos);
    assign l_ext   = (pos_ext << 1) + IW'(1);
    assign r_ext   = l_ext + IW'(1);
    assign cnt_ext = IW'(r_cnt);
    assign up_par  = (r_pos - AW'(1)) >> 1;
    assign up_par2 = (up_par - AW'(1)) >> 1;
    assign in_pos  = r_cnt[AW-1:0];
    assign in_par  = (in_pos - AW'(1)) >> 1;
    assign cnt_m1  = r_cnt - CW'(1);

    // sift-down child selection; left wins ties
    assign left_win  = f_outranks(r_val, mem_rdata_a, r_min_first);
    assign cand      = left_win ? mem_rdata_a : r_val;
    assign right_win = (r_ext < cnt_ext) && f_outranks(cand, mem_rdata_b, r_min_first);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_val       = r_val;
        n_popped    = r_popped;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_val;
        mem_raddr_a = l_ext[AW-1:0];
        mem_raddr_b = r_ext[AW-1:0];
        load_out    = 1'b0;

        case (r_state)
            S_IDLE: begin
                // prefetch: last entry for a pop, parent of the new slot for a push
                mem_raddr_a = (i_in_data.req_type == REQ_POP) ? cnt_m1[AW-1:0] : in_par;
                if (accept) begin
                    n_popped = '0;
                    n_status = ST_OK;
                    if (i_in_data.req_type == REQ_PUSH) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_val   = key_w[KEY_BITS-1:0];
                            n_pos   = in_pos;
                            n_cnt   = r_cnt + CW'(1);
                            n_state = S_UP;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_popped = r_top;
                            n_cnt    = cnt_m1;
                            n_pos    = '0;
                            n_state  = (cnt_m1 == '0) ? S_DONE : S_DN_LAST;
                        end
                    end
                end
            end
            S_UP: begin
                mem_raddr_a = up_par2;
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else if (f_outranks(mem_rdata_a, r_val, r_min_first)) begin
                    // move the parent down, climb one level
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata_a;
                    n_pos     = up_par;
                end else begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DN_LAST: begin
                n_val   = mem_rdata_a;
                n_state = S_DN_ISSUE;
            end
            S_DN_ISSUE: begin
                // children of r_pos are read on the default addresses
                if (l_ext >= cnt_ext) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN;
                end
            end
            S_DN: begin
                mem_we = 1'b1;
                if (left_win || right_win) begin
                    // move the better child up, descend one level
                    mem_wdata = right_win ? mem_rdata_b : mem_rdata_a;
                    n_pos     = right_win ? r_ext[AW-1:0] : l_ext[AW-1:0];
                    n_state   = S_DN_ISSUE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = load_out | (r_out_valid & i_out_stall);

    // result assembly
    assign top_w    = 64'(r_top);
    assign popped_w = 64'(r_popped);
    assign cnt_w    = 16'(r_cnt);

    always_comb begin
        rsp.status      = r_status;
        rsp.popped_key  = popped_w[KEY_W-1:0];
        rsp.top_key     = (r_cnt != '0) ? top_w[KEY_W-1:0] : '0;
        rsp.top_valid   = (r_cnt != '0);
        rsp.entry_count = cnt_w[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_min_first <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_min_first <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_popped <= n_popped;
        r_status <= n_status;
        // shadow the root so the top is available without a RAM read
        if (mem_we && (mem_waddr == '0)) begin
            r_top <= mem_wdata;
        end
        if (load_out) begin
            r_out <= rsp;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_binary_heap_priority_queue_core.sv =====
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue_core;
    import bph_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int RANDOM_ITEMS   = 390;  // randomized transactions with idling
    localparam int QUIET_ITEMS    = 60;   // closing transactions with no idling at all
    localparam int WATCHDOG_LIMIT = 2000; // cycles without any transaction before giving up
    localparam int DRAIN_CYCLES   = 32;   // settle window after the last result
    localparam int REPORT_LIMIT   = 10;

    typedef enum logic [1:0] {
        STEP_PUSH,
        STEP_POP,
        STEP_MIN_FIRST,
        STEP_MAX_FIRST
    } t_step_op;

    // One row of the directed table. A row with fixed set carries its expected
    // result right here; every other row is checked against the shadow heap.
    typedef struct packed {
        t_step_op         op;
        logic [KEY_W-1:0] key;
        logic             fixed;
        t_rsp             rsp;
    } t_step;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam t_rsp NO_RSP    = '{2'd0, 32'h0, 32'h0, 1'b0, 7'd0};
    localparam t_rsp EMPTY_RSP = '{ST_EMPTY, 32'h0, 32'h0, 1'b0, 7'd0};

    localparam t_step DIRECTED [25] = '{
        // pop on an empty queue right after reset
        '{STEP_POP,       32'h0,        1'b1, EMPTY_RSP},
        // extremes of the key under smallest-first ordering
        '{STEP_PUSH,      KEY_MAX,      1'b1, '{ST_OK, 32'h0, KEY_MAX, 1'b1, 7'd1}},
        '{STEP_PUSH,      32'h0,        1'b1, '{ST_OK, 32'h0, 32'h0, 1'b1, 7'd2}},
        // equal keys must not swap while sifting
        '{STEP_PUSH,      32'h0,        1'b0, NO_RSP},
        '{STEP_PUSH,      32'h1,        1'b0, NO_RSP},
        '{STEP_POP,       32'h0,        1'b0, NO_RSP},
        '{STEP_POP,       KEY_MAX,      1'b0, NO_RSP},
        '{STEP_POP,       32'h0,        1'b0, NO_RSP},
        '{STEP_POP,       32'h0,        1'b0, NO_RSP},
        '{STEP_POP,       32'h0,        1'b1, EMPTY_RSP},
        // largest-first ordering from an empty queue
        '{STEP_MAX_FIRST, 32'h0,        1'b0, NO_RSP},
        '{STEP_PUSH,      32'h12345678, 1'b1, '{ST_OK, 32'h0, 32'h12345678, 1'b1, 7'd1}},
        '{STEP_PUSH,      32'h0,        1'b0, NO_RSP},
        '{STEP_PUSH,      KEY_MAX,      1'b0, NO_RSP},
        '{STEP_PUSH,      32'h80000000, 1'b0, NO_RSP},
        '{STEP_PUSH,      KEY_MAX,      1'b0, NO_RSP},
        '{STEP_POP,       32'h0,        1'b0, NO_RSP},
        // flip the ordering with four keys held: stored order stays as it is
        '{STEP_MIN_FIRST, 32'h0,        1'b0, NO_RSP},
        '{STEP_PUSH,      32'h7,        1'b0, NO_RSP},
        '{STEP_POP,       32'h0,        1'b0, NO_RSP},
        '{STEP_POP,       KEY_MAX,      1'b0, NO_RSP},
        '{STEP_POP,       32'h55555555, 1'b0, NO_RSP},
        '{STEP_POP,       32'hAAAAAAAA, 1'b0, NO_RSP},
        '{STEP_POP,       32'h0,        1'b0, NO_RSP},
        '{STEP_POP,       32'h0,        1'b1, EMPTY_RSP}
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data  = 1'b1;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_req i_in_data   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out_data;

    // Shadow copy of the heap, its fill level and the ordering mode.
    logic [KEY_W-1:0] shadow_heap [CAPACITY];
    int unsigned      shadow_fill;
    bit               shadow_min_first;

    t_rsp        pending_rsp [$];   // expected results, oldest first
    int unsigned fault_count  = 0;
    bit          stall_enable = 1'b0;

    binary_heap_priority_queue_core #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // True when cand strictly outranks cur under the current ordering.
    function automatic bit outranks(logic [KEY_W-1:0] cur, logic [KEY_W-1:0] cand);
        return shadow_min_first ? (cand < cur) : (cand > cur);
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [KEY_W-1:0] held;
        held           = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = held;
    endfunction

    // Apply one request to the shadow heap and return the result it must produce.
    function automatic t_rsp heap_apply(t_req req);
        t_rsp        rsp;
        int unsigned pos;
        int unsigned best;
        int unsigned kid;
        bit          settled;
        rsp = '0;
        if (req.req_type == REQ_PUSH) begin
            if (shadow_fill >= CAPACITY) begin
                rsp.status = ST_FULL;
            end else begin
                // Append and climb while strictly better than the parent.
                pos              = shadow_fill;
                shadow_heap[pos] = req.key;
                while (pos > 0 && outranks(shadow_heap[(pos - 1) / 2], shadow_heap[pos])) begin
                    swap_slots(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
                shadow_fill++;
            end
        end else begin
            if (shadow_fill == 0) begin
                rsp.status = ST_EMPTY;
            end else begin
                // Take the root, refill it from the tail and sink it.
                rsp.popped_key = shadow_heap[0];
                shadow_fill--;
                shadow_heap[0] = shadow_heap[shadow_fill];
                pos     = 0;
                settled = 1'b0;
                while (!settled) begin
                    best = pos;
                    kid  = 2 * pos + 1;
                    // Left child wins a tie between the two children.
                    if (kid < shadow_fill && outranks(shadow_heap[best], shadow_heap[kid]))
                        best = kid;
                    if (kid + 1 < shadow_fill && outranks(shadow_heap[best], shadow_heap[kid + 1]))
                        best = kid + 1;
                    if (best == pos) begin
                        settled = 1'b1;
                    end else begin
                        swap_slots(pos, best);
                        pos = best;
                    end
                end
            end
        end
        rsp.top_valid   = (shadow_fill != 0);
        rsp.top_key     = (shadow_fill != 0) ? shadow_heap[0] : '0;
        rsp.entry_count = shadow_fill[CNT_W-1:0];
        return rsp;
    endfunction

    function automatic logic [KEY_W-1:0] draw_key(int unsigned style);
        case (style)
            0: return $urandom;
            // Narrow range: lots of equal keys, exercises the tie rules.
            1: return $urandom_range(0, 7);
            default: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return KEY_MAX;
                    2: return 32'h7FFFFFFF;
                    3: return 32'h80000000;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Present one request and hold it until the queue takes the transaction,
    // then record what it must answer. Valid is left high for the caller.
    task automatic put_request(t_req req, bit fixed, t_rsp fixed_rsp);
        t_rsp predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        predicted = heap_apply(req);
        pending_rsp.push_back(fixed ? fixed_rsp : predicted);
    endtask

    // Drop valid for a random burst of cycles, one time in four.
    task automatic maybe_pause(bit enabled);
        if (enabled && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Write the ordering mode once the queue has answered everything.
    task automatic set_order(bit min_first);
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= min_first;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid      <= 1'b0;
        shadow_min_first  = min_first;
    endtask

    // Output side: random stall bursts with open cycles between them, and the result
    // check on every accepted transaction.
    always @(posedge i_clk) begin : result_check
        int unsigned stall_left;
        t_rsp        want;
        if (stall_enable && stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (stall_enable && !i_out_stall && $urandom_range(0, 5) == 0) begin
            stall_left   = $urandom_range(0, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end

        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing pending: status=%0d popped=%h top=%h valid=%b count=%0d",
                             $realtime, o_out_data.status, o_out_data.popped_key,
                             o_out_data.top_key, o_out_data.top_valid, o_out_data.entry_count);
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.status      !== want.status      ||
                    o_out_data.popped_key  !== want.popped_key  ||
                    o_out_data.top_key     !== want.top_key     ||
                    o_out_data.top_valid   !== want.top_valid   ||
                    o_out_data.entry_count !== want.entry_count) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("%0t: expected status=%0d popped=%h top=%h valid=%b count=%0d",
                                 $realtime, want.status, want.popped_key, want.top_key,
                                 want.top_valid, want.entry_count);
                        $display("%0t:   actual status=%0d popped=%h top=%h valid=%b count=%0d",
                                 $realtime, o_out_data.status, o_out_data.popped_key,
                                 o_out_data.top_key, o_out_data.top_valid, o_out_data.entry_count);
                    end
                end
            end
        end
    end

    // Watchdog: give up when no channel moves a transaction for too long.
    initial begin : watchdog
        int unsigned stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        t_req        req;
        int unsigned sent;
        int unsigned phase;
        int unsigned phase_len;
        int unsigned push_pct;
        int unsigned key_style;
        bit          gaps_on;

        shadow_fill      = 0;
        shadow_min_first = 1'b1;
        foreach (shadow_heap[k]) shadow_heap[k] = '0;

        // Hold reset, then release it for good.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        stall_enable = 1'b1;
        gaps_on      = 1'($urandom_range(0, 1));
        for (int r = 0; r < $size(DIRECTED); r++) begin
            case (DIRECTED[r].op)
                STEP_MIN_FIRST: set_order(1'b1);
                STEP_MAX_FIRST: set_order(1'b0);
                default: begin
                    req.req_type = (DIRECTED[r].op == STEP_PUSH) ? REQ_PUSH : REQ_POP;
                    req.key      = DIRECTED[r].key;
                    put_request(req, DIRECTED[r].fixed, DIRECTED[r].rsp);
                    maybe_pause(gaps_on);
                end
            endcase
        end

        // Random phases. Each phase picks a push/pop mix, a key style and whether
        // either side idles; push-heavy phases are long enough to fill the heap,
        // pop-heavy ones drain it and keep popping on empty.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ((phase == 0) ? 0 : $urandom_range(0, 2))
                0:       begin push_pct = 90; phase_len = $urandom_range(80, 110); end
                1:       begin push_pct = 50; phase_len = $urandom_range(30, 70);  end
                default: begin push_pct = 15; phase_len = $urandom_range(30, 70);  end
            endcase
            // Stop the last phase at the planned item count.
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            key_style    = $urandom_range(0, 2);
            gaps_on      = ($urandom_range(0, 2) != 0);
            stall_enable = ($urandom_range(0, 2) != 0);
            // Flip the ordering now and then, usually with keys still held.
            if (phase != 0 && $urandom_range(0, 1) == 1)
                set_order(1'($urandom_range(0, 1)));
            repeat (phase_len) begin
                req.req_type = ($urandom_range(1, 100) <= push_pct) ? REQ_PUSH : REQ_POP;
                req.key      = draw_key(key_style);
                put_request(req, 1'b0, NO_RSP);
                maybe_pause(gaps_on);
                sent++;
            end
            phase++;
        end

        // Closing stretch at full rate on both sides.
        stall_enable = 1'b0;
        key_style    = $urandom_range(0, 2);
        repeat (QUIET_ITEMS) begin
            req.req_type = ($urandom_range(0, 1) == 0) ? REQ_PUSH : REQ_POP;
            req.key      = draw_key(key_style);
            put_request(req, 1'b0, NO_RSP);
        end
        i_in_valid <= 1'b0;

        // Wait for the last result, then give stray results a chance to show up.
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bph_pkg.sv
src/bph_heap_mem.sv
src/binary_heap_priority_queue_core.sv
tb/tb_binary_heap_priority_queue_core.sv
